>>> hdl/dcav_pkg.sv
`timescale 1ns / 1ps

package dcav_pkg;

  // Field widths of the channels.
  localparam int SAMPLE_W = 16;
  localparam int READ_W   = 12;

  // Magnitude of a sample, wide enough for the most negative code.
  localparam int MAG_W = SAMPLE_W + 1;

  // Multiplier operand of the square unit: the magnitude never exceeds 2^15.
  localparam int SQ_W = SAMPLE_W;

  // Window sum of squares, and the radicand and root of the square root unit.
  localparam int SUM_W  = 39;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = RAD_W / 2;

  // One count is 1/20 of a hundredth of a volt.
  localparam int SCALE_DIV = 20;

  // Start values of the peak holds.
  localparam logic signed [READ_W-1:0] HOLD_MAX_START = -12'sd1000;
  localparam logic signed [READ_W-1:0] HOLD_MIN_START = 12'sd1000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [READ_W-1:0]   reading_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [RAD_W-1:0]           rad_t;
  typedef logic [ROOT_W-1:0]          root_t;

  // Handshake between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
    logic clear;
  } unit_ctl_t;

endpackage

>>> hdl/dcav_if.sv
`timescale 1ns / 1ps

// Sample channel.
interface dcav_in_if import dcav_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    mode;
  sample_t sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

// Result channel.
interface dcav_out_if import dcav_pkg::*; ();
  logic     valid;
  logic     ready;
  reading_t reading;
  reading_t peak_high;
  reading_t peak_low;

  modport source (output valid, output reading, output peak_high, output peak_low,
                  input ready);
  modport sink (input valid, input reading, input peak_high, input peak_low,
                output ready);
endinterface

// Configuration write channel.
interface dcav_cfg_if import dcav_pkg::*; ();
  logic valid;
  logic ready;
  logic measure_ac;

  modport source (output valid, output measure_ac, input ready);
  modport sink (input valid, input measure_ac, output ready);
endinterface

>>> hdl/dcav_cdiv.sv
`timescale 1ns / 1ps

// Restoring division by a constant, one quotient bit per cycle.
module dcav_cdiv import dcav_pkg::*; #(
  parameter int DW      = 17,
  parameter int DIVISOR = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int CW = $clog2(DW + 1);
  localparam logic [RW:0] DIV_C = DIVISOR[RW:0];

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [RW-1:0] rem_r;

  logic [RW:0]   rem_sh;
  logic [RW:0]   rem_diff;
  logic          ge;
  logic [DW-1:0] quo_nxt;
  logic [RW-1:0] rem_nxt;

  // One step: bring in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    rem_diff = rem_sh - DIV_C;
    ge       = (rem_sh >= DIV_C);
    quo_nxt  = {quo_r[DW-2:0], ge};
    rem_nxt  = ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/dcav_isqrt.sv
`timescale 1ns / 1ps

// Floor square root, one root bit (two radicand bits) per cycle.
module dcav_isqrt import dcav_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  rad_t  radicand,
  output logic  done,
  output root_t root
);

  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RMW = ROOT_W + 1;

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  rad_t           rad_r;
  logic [RMW-1:0] rem_r;
  root_t          root_r;

  logic [RMW+1:0] rem_sh;
  logic [RMW+1:0] trial;
  logic [RMW+1:0] rem_diff;
  logic           ge;
  logic [RMW-1:0] rem_nxt;
  root_t          root_nxt;

  // Trial subtraction of 4*root+1 from the remainder with two new bits.
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? rem_diff[RMW-1:0] : rem_sh[RMW-1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hdl/dcav_sqacc.sv
`timescale 1ns / 1ps

// Shift-and-add squaring into the window sum, one multiplier bit per cycle.
module dcav_sqacc import dcav_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  unit_ctl_t       ctl,
  input  logic [SQ_W-1:0] mag,
  output logic            done,
  output sum_t            sum
);

  localparam int CW  = $clog2(SQ_W + 1);
  localparam int PW  = 2 * SQ_W - 1;

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  sum_t            sum_r;
  logic [PW-1:0]   mcand_r;
  logic [SQ_W-1:0] mplier_r;

  sum_t            sum_nxt;

  // Add the shifted multiplicand when the current multiplier bit is set.
  always_comb begin
    sum_nxt = sum_r;
    if (mplier_r[0]) begin
      sum_nxt = sum_r + SUM_W'(mcand_r);
    end
  end

  // Control and the window sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (ctl.clear) begin
        sum_r <= '0;
      end else if (busy_r) begin
        sum_r <= sum_nxt;
      end
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SQ_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Operand shift registers.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand_r  <= PW'(mag);
      mplier_r <= mag;
    end else if (busy_r) begin
      mcand_r  <= {mcand_r[PW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[SQ_W-1:1]};
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

>>> hdl/dc_ac_voltage_meter_minmax.sv
`timescale 1ns / 1ps

// Voltage meter with running peak hold. Each signed converter sample reads as
// sample/20 hundredths of a volt. With measure_ac clear, every sample beat that
// is not a clear beat gives one reading through the bit-serial divide by 20.
// With measure_ac set, a sample is squared into the window sum by a bit-serial
// multiplier; the last sample of a window then runs a serial divide by
// WINDOW_LENGTH, a serial square root and the divide by 20, which gives its RMS
// reading. One sample is in work at a time; a finished beat waits in the output
// register while the next sample is taken. A clear beat (mode set) or a write
// of measure_ac resets the peaks to -10.00 V / +10.00 V and restarts the window.
module dc_ac_voltage_meter_minmax import dcav_pkg::*; #(
  parameter int WINDOW_LENGTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  dcav_in_if.sink    in_bus,
  dcav_out_if.source out_bus,
  dcav_cfg_if.sink   cfg_bus
);

  localparam int CNT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQACC = 3'd1;
  localparam logic [2:0] ST_WDIV  = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_SDIV  = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  logic [2:0]       state_r;
  logic             measure_ac_r;
  logic [CNT_W-1:0] count_r;
  logic             last_r;
  logic             neg_r;
  reading_t         reading_r;
  reading_t         max_hold_r;
  reading_t         min_hold_r;
  logic             out_valid_r;
  reading_t         out_reading_r;
  reading_t         out_high_r;
  reading_t         out_low_r;

  logic      in_fire;
  logic      cfg_fire;
  logic      clear_all;
  logic      push;
  mag_t      in_ext;
  mag_t      in_mag;
  unit_ctl_t acc_ctl;
  logic      acc_done;
  sum_t      acc_sum;
  logic      wdiv_start;
  logic      wdiv_done;
  sum_t      wdiv_q;
  logic      sqrt_start;
  logic      sqrt_done;
  root_t     sqrt_root;
  logic      sdiv_start;
  mag_t      sdiv_in;
  logic      sdiv_done;
  mag_t      sdiv_q;
  reading_t  q_read;
  reading_t  reading_nxt;
  reading_t  max_nxt;
  reading_t  min_nxt;

  // Handshakes.
  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_fire      = cfg_bus.valid;
  assign clear_all     = cfg_fire || (in_fire && in_bus.mode);
  assign push          = (state_r == ST_PUSH) && (!out_valid_r || out_bus.ready);

  // Magnitude of the incoming sample.
  assign in_ext = {in_bus.sample[SAMPLE_W-1], in_bus.sample};
  assign in_mag = in_bus.sample[SAMPLE_W-1] ? (~in_ext + 1'b1) : in_ext;

  // Unit starts.
  assign acc_ctl.start = in_fire && !in_bus.mode && measure_ac_r;
  assign acc_ctl.clear = clear_all || ((state_r == ST_SQACC) && acc_done && last_r);
  assign wdiv_start    = (state_r == ST_SQACC) && acc_done && last_r;
  assign sqrt_start    = (state_r == ST_WDIV) && wdiv_done;
  assign sdiv_start    = (in_fire && !in_bus.mode && !measure_ac_r) ||
                         ((state_r == ST_SQRT) && sqrt_done);
  assign sdiv_in       = (state_r == ST_SQRT) ? MAG_W'(sqrt_root) : in_mag;

  dcav_sqacc u_sqacc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .mag   (in_mag[SQ_W-1:0]),
    .done  (acc_done),
    .sum   (acc_sum)
  );

  dcav_cdiv #(
    .DW      (SUM_W),
    .DIVISOR (WINDOW_LENGTH)
  ) u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wdiv_start),
    .dividend (acc_sum),
    .done     (wdiv_done),
    .quotient (wdiv_q)
  );

  dcav_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (wdiv_q[RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  dcav_cdiv #(
    .DW      (MAG_W),
    .DIVISOR (SCALE_DIV)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sdiv_start),
    .dividend (sdiv_in),
    .done     (sdiv_done),
    .quotient (sdiv_q)
  );

  // Signed reading and the updated peaks.
  always_comb begin
    q_read      = sdiv_q[READ_W-1:0];
    reading_nxt = neg_r ? (~q_read + 1'b1) : q_read;
    max_nxt     = (reading_r > max_hold_r) ? reading_r : max_hold_r;
    min_nxt     = (reading_r < min_hold_r) ? reading_r : min_hold_r;
  end

  // Sequencer, window count and peak holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      measure_ac_r <= 1'b0;
      count_r      <= '0;
      last_r       <= 1'b0;
      max_hold_r   <= HOLD_MAX_START;
      min_hold_r   <= HOLD_MIN_START;
    end else begin
      if (cfg_fire) begin
        measure_ac_r <= cfg_bus.measure_ac;
      end
      if (clear_all) begin
        count_r    <= '0;
        max_hold_r <= HOLD_MAX_START;
        min_hold_r <= HOLD_MIN_START;
      end else if (push) begin
        max_hold_r <= max_nxt;
        min_hold_r <= min_nxt;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && !in_bus.mode) begin
            if (measure_ac_r) begin
              last_r <= (count_r == CNT_W'(WINDOW_LENGTH - 1));
              if (count_r == CNT_W'(WINDOW_LENGTH - 1)) begin
                count_r <= '0;
              end else begin
                count_r <= count_r + 1'b1;
              end
              state_r <= ST_SQACC;
            end else begin
              state_r <= ST_SDIV;
            end
          end
        end
        ST_SQACC: begin
          if (acc_done) begin
            state_r <= last_r ? ST_WDIV : ST_IDLE;
          end
        end
        ST_WDIV: begin
          if (wdiv_done) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state_r <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (sdiv_done) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Sign of the reading and the reading itself.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg_r <= !measure_ac_r && in_bus.sample[SAMPLE_W-1];
    end
    if ((state_r == ST_SDIV) && sdiv_done) begin
      reading_r <= reading_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_reading_r <= reading_r;
      out_high_r    <= max_nxt;
      out_low_r     <= min_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.reading   = out_reading_r;
  assign out_bus.peak_high = out_high_r;
  assign out_bus.peak_low  = out_low_r;

endmodule
